>>> design/climate_fan_pwm_controller_core_assert.svh
// Assertion macros for the climate fan PWM controller core.
// Included by cfpc_engine, the RTL file that checks its own control state.
`ifndef CLIMATE_FAN_PWM_CONTROLLER_CORE_ASSERT_SVH
`define CLIMATE_FAN_PWM_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfpc check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define CFPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfpc check failed: next-cycle implication");

`endif

>>> design/cfpc_pkg.sv
// Shared types, codes and reset values for the climate fan PWM controller core.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfpc_pkg;

   // Transaction payloads
   typedef struct packed {
      logic [3:0] op;
      logic [2:0] device;
      logic [7:0] set_value;
      logic [9:0] temperature_sample;
      logic [9:0] light_sample;
   } req_type;

   typedef struct packed {
      logic       response;
      logic       response_valid;
      logic       fan_enable;
      logic [1:0] fan_direction;
      logic       heater_on;
      logic [5:0] lights;
   } rsp_type;

   // Configuration register file contents
   typedef struct packed {
      logic [9:0] light_threshold;
      logic [7:0] heater_below;
      logic [7:0] ac_above;
      logic [7:0] fan_start;
      logic [7:0] fan_full;
      logic [7:0] pwm_period;
      logic [7:0] sensor_period;
   } cfg_type;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 10;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_LIGHT_THRESHOLD = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HEATER_BELOW    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_AC_ABOVE        = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_FAN_START       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_FAN_FULL        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PWM_PERIOD      = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_SENSOR_PERIOD   = 3'd6;

   // Register reset values
   localparam logic [9:0] RST_LIGHT_THRESHOLD = 10'd512;
   localparam logic [7:0] RST_HEATER_BELOW    = 8'd10;
   localparam logic [7:0] RST_AC_ABOVE        = 8'd25;
   localparam logic [7:0] RST_FAN_START       = 8'd30;
   localparam logic [7:0] RST_FAN_FULL        = 8'd40;
   localparam logic [7:0] RST_PWM_PERIOD      = 8'd100;
   localparam logic [7:0] RST_SENSOR_PERIOD   = 8'd150;
   localparam logic [7:0] RST_TARGET_TEMP     = 8'd24;

   // Operation codes
   localparam logic [3:0] OP_TICK        = 4'd0;
   localparam logic [3:0] OP_STATUS      = 4'd1;
   localparam logic [3:0] OP_ON          = 4'd2;
   localparam logic [3:0] OP_OFF         = 4'd3;
   localparam logic [3:0] OP_CLIMATE_ON  = 4'd4;
   localparam logic [3:0] OP_CLIMATE_OFF = 4'd5;
   localparam logic [3:0] OP_SET_TARGET  = 4'd6;
   localparam logic [3:0] OP_BLOWER_ON   = 4'd7;
   localparam logic [3:0] OP_BLOWER_OFF  = 4'd8;
   localparam logic [3:0] OP_LIGHT_QUERY = 4'd9;

   // Devices
   localparam logic [2:0] DEV_LAST_ROOM = 3'd3;
   localparam logic [2:0] DEV_AC        = 3'd4;
   localparam logic [2:0] DEV_TV        = 3'd5;

   // Fan directions
   localparam logic [1:0] FAN_STOP    = 2'd0;
   localparam logic [1:0] FAN_FORWARD = 2'd1;
   localparam logic [1:0] FAN_REVERSE = 2'd2;

endpackage

`default_nettype wire

>>> design/cfpc_csr.sv
// Configuration register file of the climate fan PWM controller core.
// Depends on cfpc_pkg for the register layout, indexes and reset values.
`default_nettype none

module cfpc_csr
   import cfpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LIGHT_THRESHOLD: cfg_in.light_threshold = csr_write_data;
            CSR_HEATER_BELOW:    cfg_in.heater_below    = csr_write_data[7:0];
            CSR_AC_ABOVE:        cfg_in.ac_above        = csr_write_data[7:0];
            CSR_FAN_START:       cfg_in.fan_start       = csr_write_data[7:0];
            CSR_FAN_FULL:        cfg_in.fan_full        = csr_write_data[7:0];
            CSR_PWM_PERIOD:      cfg_in.pwm_period      = csr_write_data[7:0];
            CSR_SENSOR_PERIOD:   cfg_in.sensor_period   = csr_write_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold <= RST_LIGHT_THRESHOLD;
         cfg_ff.heater_below    <= RST_HEATER_BELOW;
         cfg_ff.ac_above        <= RST_AC_ABOVE;
         cfg_ff.fan_start       <= RST_FAN_START;
         cfg_ff.fan_full        <= RST_FAN_FULL;
         cfg_ff.pwm_period      <= RST_PWM_PERIOD;
         cfg_ff.sensor_period   <= RST_SENSOR_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/cfpc_engine.sv
// Controller state and its per-transaction update: PWM, sensor timer, climate, lights.
// Depends on cfpc_pkg and the assertion macro header.
`default_nettype none
`include "climate_fan_pwm_controller_core_assert.svh"

module cfpc_engine
   import cfpc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [7:0] pwm_count_ff, pwm_count_in;
   logic [7:0] sensor_count_ff, sensor_count_in;
   logic [7:0] fan_duty_ff, fan_duty_in;
   logic [1:0] fan_dir_ff, fan_dir_in;
   logic       fan_pin_ff, fan_pin_in;
   logic       blower_ff, blower_in;
   logic       climate_en_ff, climate_en_in;
   logic [7:0] target_ff, target_in;
   logic       heater_ff, heater_in;
   logic [5:0] lights_ff, lights_in;

   logic [7:0]  pwm_inc;
   logic [7:0]  sensor_inc;
   logic [7:0]  temp;
   logic [7:0]  temp_excess;
   logic [11:0] duty_scaled;
   logic [7:0]  duty_auto;
   logic        switchable;
   logic        resp;
   logic        resp_valid;
   logic        off_cmd;

   assign pwm_inc     = pwm_count_ff + 8'd1;
   assign sensor_inc  = sensor_count_ff + 8'd1;
   assign temp        = item.temperature_sample[9:2];
   assign temp_excess = temp - cfg.fan_start;
   // Times ten as eight plus two.
   assign duty_scaled = {1'b0, temp_excess, 3'b000} + {3'b000, temp_excess, 1'b0};
   assign switchable  = (item.device <= DEV_LAST_ROOM) || (item.device == DEV_TV);
   assign off_cmd     = fire && (item.op == OP_CLIMATE_OFF);

   always_comb begin
      if (temp >= cfg.fan_full) begin
         duty_auto = cfg.pwm_period;
      end else if (duty_scaled > 12'd255) begin
         duty_auto = 8'd255;
      end else begin
         duty_auto = duty_scaled[7:0];
      end
   end

   always_comb begin
      pwm_count_in    = pwm_count_ff;
      sensor_count_in = sensor_count_ff;
      fan_duty_in     = fan_duty_ff;
      fan_dir_in      = fan_dir_ff;
      fan_pin_in      = fan_pin_ff;
      blower_in       = blower_ff;
      climate_en_in   = climate_en_ff;
      target_in       = target_ff;
      heater_in       = heater_ff;
      lights_in       = lights_ff;
      resp            = 1'b0;
      resp_valid      = 1'b0;

      unique case (item.op)
         OP_TICK: begin
            pwm_count_in = (pwm_inc >= cfg.pwm_period) ? 8'd0 : pwm_inc;
            // The pin compares against the duty held before this evaluation.
            fan_pin_in = (pwm_count_in < fan_duty_ff);
            if (sensor_inc >= cfg.sensor_period) begin
               sensor_count_in = 8'd0;
               if (climate_en_ff) begin
                  heater_in = (temp < cfg.heater_below);
                  if (temp > cfg.ac_above) begin
                     lights_in[DEV_AC] = 1'b1;
                  end else if (temp < target_ff) begin
                     lights_in[DEV_AC] = 1'b0;
                  end
                  if (!blower_ff) begin
                     if (temp > cfg.fan_start) begin
                        fan_dir_in  = FAN_FORWARD;
                        fan_duty_in = duty_auto;
                     end else begin
                        fan_dir_in  = FAN_STOP;
                        fan_duty_in = 8'd0;
                     end
                  end
               end else begin
                  lights_in[DEV_AC] = 1'b0;
                  heater_in         = 1'b0;
                  if (!blower_ff) begin
                     fan_dir_in  = FAN_STOP;
                     fan_duty_in = 8'd0;
                  end
               end
            end else begin
               sensor_count_in = sensor_inc;
            end
         end
         OP_STATUS: begin
            resp_valid = 1'b1;
            if (item.device <= DEV_TV) begin
               resp = lights_ff[item.device];
            end
         end
         OP_ON: begin
            if (switchable) begin
               lights_in[item.device] = 1'b1;
            end
         end
         OP_OFF: begin
            if (switchable) begin
               lights_in[item.device] = 1'b0;
            end
         end
         OP_CLIMATE_ON: begin
            climate_en_in = 1'b1;
         end
         OP_CLIMATE_OFF: begin
            climate_en_in     = 1'b0;
            lights_in[DEV_AC] = 1'b0;
            heater_in         = 1'b0;
         end
         OP_SET_TARGET: begin
            target_in = item.set_value;
         end
         OP_BLOWER_ON: begin
            blower_in   = 1'b1;
            fan_dir_in  = FAN_REVERSE;
            fan_duty_in = cfg.pwm_period;
         end
         OP_BLOWER_OFF: begin
            blower_in   = 1'b0;
            fan_dir_in  = FAN_STOP;
            fan_duty_in = 8'd0;
         end
         OP_LIGHT_QUERY: begin
            resp_valid = 1'b1;
            resp       = (item.light_sample > cfg.light_threshold);
         end
         default: begin
            resp = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff    <= 8'd0;
         sensor_count_ff <= 8'd0;
         fan_duty_ff     <= 8'd0;
         fan_dir_ff      <= FAN_STOP;
         fan_pin_ff      <= 1'b0;
         blower_ff       <= 1'b0;
         climate_en_ff   <= 1'b1;
         target_ff       <= RST_TARGET_TEMP;
         heater_ff       <= 1'b0;
         lights_ff       <= 6'd0;
      end else if (fire) begin
         pwm_count_ff    <= pwm_count_in;
         sensor_count_ff <= sensor_count_in;
         fan_duty_ff     <= fan_duty_in;
         fan_dir_ff      <= fan_dir_in;
         fan_pin_ff      <= fan_pin_in;
         blower_ff       <= blower_in;
         climate_en_ff   <= climate_en_in;
         target_ff       <= target_in;
         heater_ff       <= heater_in;
         lights_ff       <= lights_in;
      end
   end

   assign result.response       = resp;
   assign result.response_valid = resp_valid;
   assign result.fan_enable     = fan_pin_in;
   assign result.fan_direction  = fan_dir_in;
   assign result.heater_on      = heater_in;
   assign result.lights         = lights_in;

   `CFPC_ASSERT_NOW(a_heater_needs_climate, clock, reset, !climate_en_ff, !heater_ff)
   `CFPC_ASSERT_NOW(a_ac_needs_climate, clock, reset, !climate_en_ff, !lights_ff[DEV_AC])
   `CFPC_ASSERT_NOW(a_blower_reverse, clock, reset, blower_ff, fan_dir_ff == FAN_REVERSE)
   `CFPC_ASSERT_NEXT(a_climate_off_clears, clock, reset, off_cmd, !climate_en_ff && !heater_ff)

endmodule

`default_nettype wire

>>> design/climate_fan_pwm_controller_core.sv
// Climate fan PWM controller core: one transaction in, one transaction out.
// A request is captured in the input register at acceptance; once the response register
// can take an entry, the engine processes it and the response register captures the result.
// Throughput: one transaction per cycle while the response side keeps up.
// Reset (synchronous, active high) restores valid flags, configuration and controller state; payloads carry none.
// Depends on cfpc_pkg, cfpc_csr and cfpc_engine.
`default_nettype none

module climate_fan_pwm_controller_core
   import cfpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_payload,
   // Response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_payload,
   // Configuration write port
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   // Pipeline: an input register holds an accepted transaction; when the response
   // register can take a new entry, the engine applies the transaction to the
   // controller state and the response register captures the result in the
   // same edge. Both registers are in flight at once, so a request can be taken
   // every cycle while the downstream side keeps up.

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;

   logic    out_load;   // response register free or being drained this cycle
   logic    fire;       // buffered transaction moves into the engine
   cfg_type cfg;
   rsp_type result;

   assign out_load  = !out_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && out_load;
   assign req_ready = !in_vld_ff || out_load;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
      end
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   // The user must write configuration only while the block is idle; the block does not enforce it.
   cfpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cfpc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

>>> bench/climate_fan_pwm_controller_core_tb.sv
// Self-checking testbench for the climate fan PWM controller core.
// Depends on cfpc_pkg and the climate_fan_pwm_controller_core RTL; nothing else.
// It drives requests through a directed table and then through random phases.

module climate_fan_pwm_controller_core_tb;
   import cfpc_pkg::*;

   // Run-wide constants. The timeout is far beyond the slowest legal run:
   // about 750 transactions, each paying the longest sender gap, the longest
   // receiver stall and the trip through the pipeline, plus one long hold-off.
   localparam int unsigned HALF_PERIOD    = 4;
   localparam int unsigned LIMIT_TIME     = 2_000_000;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned HOLD_CYCLES    = 48;
   localparam int unsigned FAN_RAMP_STEP  = 10;
   localparam logic [3:0]  OP_LAST_CODE   = 4'hF;
   localparam logic [2:0]  DEV_FIRST_ROOM = 3'd0;
   localparam logic [2:0]  DEV_SPARE      = 3'd7;

   // One row of the directed table. A pinned row carries its own expected
   // reply instead of asking the predictor for one.
   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type reply;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_payload;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_write_data;

   // Sideband that travels with the offered request, so that the monitor
   // knows at acceptance whether the expected reply was typed in by hand.
   logic    req_pinned;
   rsp_type req_pinned_rsp;

   // The predictor's copy of the registers and of the controller state.
   cfg_type    live_cfg;
   logic [7:0] pwm_ticks;
   logic [7:0] sensor_ticks;
   logic [7:0] duty_level;
   logic [1:0] fan_mode;
   logic       fan_level;
   logic       blower_on;
   logic       climate_on;
   logic [7:0] target_setpoint;
   logic       heater_level;
   logic [5:0] lamp_bits;

   // Pin snapshots predicted for accepted requests, oldest first.
   rsp_type      pin_snapshots [$];
   plan_row_type directed_plan [$];

   int unsigned failures = 0;
   bit          steady_traffic = 1'b0;
   bit          hold_requested = 1'b0;

   climate_fan_pwm_controller_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Predicts the pin snapshot that one request leaves behind and advances
   // the predictor state. A tick moves the PWM counter and, once every
   // sensor period, runs the climate evaluation on t = sample / 4.
   function automatic rsp_type next_pin_snapshot(input req_type item);
      rsp_type     snap;
      logic [7:0]  t;
      int unsigned ramp;
      logic        switchable;
      snap       = '0;
      t          = item.temperature_sample[9:2];
      switchable = (item.device <= DEV_LAST_ROOM) || (item.device == DEV_TV);
      case (item.op)
         OP_TICK: begin
            pwm_ticks = pwm_ticks + 8'd1;
            if (pwm_ticks >= live_cfg.pwm_period) pwm_ticks = '0;
            fan_level    = (pwm_ticks < duty_level);
            sensor_ticks = sensor_ticks + 8'd1;
            if (sensor_ticks >= live_cfg.sensor_period) begin
               sensor_ticks = '0;
               if (climate_on) begin
                  heater_level = (t < live_cfg.heater_below);
                  // The AC has a dead band: it stays as it is between the
                  // target and the switch-on temperature.
                  if (t > live_cfg.ac_above) lamp_bits[DEV_AC] = 1'b1;
                  else if (t < target_setpoint) lamp_bits[DEV_AC] = 1'b0;
                  if (!blower_on) begin
                     if (t > live_cfg.fan_start) begin
                        fan_mode = FAN_FORWARD;
                        if (t >= live_cfg.fan_full) begin
                           duty_level = live_cfg.pwm_period;
                        end else begin
                           ramp = (32'(t) - 32'(live_cfg.fan_start)) * FAN_RAMP_STEP;
                           duty_level = (ramp > 255) ? 8'd255 : ramp[7:0];
                        end
                     end else begin
                        fan_mode   = FAN_STOP;
                        duty_level = '0;
                     end
                  end
               end else begin
                  lamp_bits[DEV_AC] = 1'b0;
                  heater_level      = 1'b0;
                  if (!blower_on) begin
                     fan_mode   = FAN_STOP;
                     duty_level = '0;
                  end
               end
            end
         end
         OP_STATUS: begin
            snap.response_valid = 1'b1;
            if (item.device <= DEV_TV) snap.response = lamp_bits[item.device];
         end
         OP_ON: begin
            if (switchable) lamp_bits[item.device] = 1'b1;
         end
         OP_OFF: begin
            if (switchable) lamp_bits[item.device] = 1'b0;
         end
         OP_CLIMATE_ON: begin
            climate_on = 1'b1;
         end
         OP_CLIMATE_OFF: begin
            climate_on        = 1'b0;
            lamp_bits[DEV_AC] = 1'b0;
            heater_level      = 1'b0;
         end
         OP_SET_TARGET: begin
            target_setpoint = item.set_value;
         end
         OP_BLOWER_ON: begin
            blower_on  = 1'b1;
            fan_mode   = FAN_REVERSE;
            duty_level = live_cfg.pwm_period;
         end
         OP_BLOWER_OFF: begin
            blower_on  = 1'b0;
            fan_mode   = FAN_STOP;
            duty_level = '0;
         end
         OP_LIGHT_QUERY: begin
            snap.response_valid = 1'b1;
            snap.response       = (item.light_sample > live_cfg.light_threshold);
         end
         default: begin
         end
      endcase
      snap.fan_enable    = fan_level;
      snap.fan_direction = fan_mode;
      snap.heater_on     = heater_level;
      snap.lights        = lamp_bits;
      return snap;
   endfunction

   // Builds a directed row. Pinned rows are status or light query replies taken while
   // every pin is still at its reset level, so only the reply bit varies.
   function automatic plan_row_type plan(input logic [3:0] op, input logic [2:0] device,
                                         input logic [7:0] set_value,
                                         input logic [9:0] temperature,
                                         input logic [9:0] light,
                                         input logic pinned = 1'b0,
                                         input logic reply = 1'b0);
      plan_row_type r;
      r                           = '0;
      r.item.op                   = op;
      r.item.device               = device;
      r.item.set_value            = set_value;
      r.item.temperature_sample   = temperature;
      r.item.light_sample         = light;
      r.pinned                    = pinned;
      r.reply.response            = reply;
      r.reply.response_valid      = pinned;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [9:0] want,
                              input logic [9:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   // Monitor. Everything is sampled at the rising edge, before the
   // nonblocking updates of that edge land, so the order of processes
   // within the time step does not matter.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LIGHT_THRESHOLD: live_cfg.light_threshold = csr_write_data;
               CSR_HEATER_BELOW:    live_cfg.heater_below    = csr_write_data[7:0];
               CSR_AC_ABOVE:        live_cfg.ac_above        = csr_write_data[7:0];
               CSR_FAN_START:       live_cfg.fan_start       = csr_write_data[7:0];
               CSR_FAN_FULL:        live_cfg.fan_full        = csr_write_data[7:0];
               CSR_PWM_PERIOD:      live_cfg.pwm_period      = csr_write_data[7:0];
               CSR_SENSOR_PERIOD:   live_cfg.sensor_period   = csr_write_data[7:0];
               default: begin
               end
            endcase
         end
         // A response can never belong to a request accepted at the same
         // edge, so the check runs before the new expectation is queued.
         if (rsp_valid && rsp_ready) begin
            if (pin_snapshots.size() == 0) begin
               $error("response transaction with no request outstanding");
               failures++;
            end else begin
               want = pin_snapshots.pop_front();
               check_field("response", 10'(want.response), 10'(rsp_payload.response));
               check_field("response_valid", 10'(want.response_valid),
                           10'(rsp_payload.response_valid));
               check_field("fan_enable", 10'(want.fan_enable), 10'(rsp_payload.fan_enable));
               check_field("fan_direction", 10'(want.fan_direction),
                           10'(rsp_payload.fan_direction));
               check_field("heater_on", 10'(want.heater_on), 10'(rsp_payload.heater_on));
               check_field("lights", 10'(want.lights), 10'(rsp_payload.lights));
            end
         end
         if (req_valid && req_ready) begin
            // The predictor always runs so that its state stays in step,
            // even when the row supplies its own expected reply.
            want = next_pin_snapshot(req_payload);
            if (req_pinned) want = req_pinned_rsp;
            pin_snapshots.push_back(want);
         end
      end
   end

   // Receiver. It drives ready and not ready in random bursts, holds ready in
   // steady traffic, and honors one long hold-off on request. The hold is
   // counted here so that the sender keeps offering meanwhile and the
   // block has to fill up and drop req_ready.
   initial begin : receiver
      logic        level;
      int unsigned span;
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            level          = 1'b0;
            span           = HOLD_CYCLES;
         end else if (steady_traffic || $urandom_range(0, 2) != 0) begin
            level = 1'b1;
            span  = $urandom_range(1, 13);
         end else begin
            level = 1'b0;
            span  = $urandom_range(1, 13);
         end
         rsp_ready <= level;
         repeat (span) @(posedge clock);
      end
   end

   // Offers one request and returns at the edge where it was accepted.
   task automatic offer_request(input req_type item, input logic pinned,
                                input rsp_type reply);
      req_valid      <= 1'b1;
      req_payload    <= item;
      req_pinned     <= pinned;
      req_pinned_rsp <= reply;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   // Drops valid for a random burst now and then, except in steady traffic.
   task automatic sender_gap();
      if (!steady_traffic && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Waits until every expected response has arrived, then lets the block settle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pin_snapshots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type s);
      write_register(CSR_LIGHT_THRESHOLD, s.light_threshold);
      write_register(CSR_HEATER_BELOW,    CsrDataWidth'(s.heater_below));
      write_register(CSR_AC_ABOVE,        CsrDataWidth'(s.ac_above));
      write_register(CSR_FAN_START,       CsrDataWidth'(s.fan_start));
      write_register(CSR_FAN_FULL,        CsrDataWidth'(s.fan_full));
      write_register(CSR_PWM_PERIOD,      CsrDataWidth'(s.pwm_period));
      write_register(CSR_SENSOR_PERIOD,   CsrDataWidth'(s.sensor_period));
      csr_write_enable <= 1'b0;
   endtask

   // One random phase under fixed settings. About half the ticks carry a
   // temperature within two degrees of a threshold or of the target, and
   // about half the light queries a sample next to the light threshold,
   // so that every comparison is hit on both sides.
   task automatic run_phase(input cfg_type setting, input int unsigned count,
                            input bit squeeze);
      req_type     item;
      int unsigned i;
      int unsigned roll;
      int          near;
      logic [7:0]  anchor;
      load_settings(setting);
      for (i = 0; i < count; i++) begin
         if (i != 0) sender_gap();
         if (squeeze && i == count / 4) hold_requested = 1'b1;
         item           = '0;
         item.set_value = 8'($urandom_range(0, 255));
         item.device    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                      : 3'($urandom_range(0, DEV_TV));
         roll = $urandom_range(0, 99);
         if (roll < 48) item.op = OP_TICK;
         else if (roll < 56) item.op = OP_STATUS;
         else if (roll < 64) item.op = OP_ON;
         else if (roll < 70) item.op = OP_OFF;
         else if (roll < 75) item.op = OP_CLIMATE_ON;
         else if (roll < 78) item.op = OP_CLIMATE_OFF;
         else if (roll < 83) item.op = OP_SET_TARGET;
         else if (roll < 87) item.op = OP_BLOWER_ON;
         else if (roll < 91) item.op = OP_BLOWER_OFF;
         else if (roll < 97) item.op = OP_LIGHT_QUERY;
         else item.op = 4'($urandom_range(OP_LIGHT_QUERY + 1, OP_LAST_CODE));
         if ($urandom_range(0, 1) == 0) begin
            item.temperature_sample = 10'($urandom_range(0, 1023));
         end else begin
            case ($urandom_range(0, 4))
               0:       anchor = setting.heater_below;
               1:       anchor = setting.ac_above;
               2:       anchor = setting.fan_start;
               3:       anchor = setting.fan_full;
               default: anchor = target_setpoint;
            endcase
            near = int'(anchor) + int'($urandom_range(0, 4)) - 2;
            if (near < 0) near = 0;
            if (near > 255) near = 255;
            item.temperature_sample = 10'(near * 4 + int'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 1) == 0) begin
            item.light_sample = 10'($urandom_range(0, 1023));
         end else begin
            near = int'(setting.light_threshold) + int'($urandom_range(0, 4)) - 2;
            if (near < 0) near = 0;
            if (near > 1023) near = 1023;
            item.light_sample = 10'(near);
         end
         offer_request(item, 1'b0, '0);
      end
      settle();
   endtask

   // Main sequence: reset, directed table, then the random phases.
   initial begin : stimulus
      cfg_type     defaults;
      cfg_type     setting;
      int unsigned row;
      int unsigned round;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      req_pinned       <= 1'b0;
      req_pinned_rsp   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;

      defaults.light_threshold = RST_LIGHT_THRESHOLD;
      defaults.heater_below    = RST_HEATER_BELOW;
      defaults.ac_above        = RST_AC_ABOVE;
      defaults.fan_start       = RST_FAN_START;
      defaults.fan_full        = RST_FAN_FULL;
      defaults.pwm_period      = RST_PWM_PERIOD;
      defaults.sensor_period   = RST_SENSOR_PERIOD;

      // Predictor state after reset.
      live_cfg        = defaults;
      pwm_ticks       = '0;
      sensor_ticks    = '0;
      duty_level      = '0;
      fan_mode        = FAN_STOP;
      fan_level       = 1'b0;
      blower_on       = 1'b0;
      climate_on      = 1'b1;
      target_setpoint = RST_TARGET_TEMP;
      heater_level    = 1'b0;
      lamp_bits       = '0;

      // The first six rows run on the reset state with the reset light
      // threshold, so their replies can be written down directly. The rest
      // cover every operation, every device code including the spare ones,
      // the extreme samples, the blower overriding the auto fan, climate
      // control switched off while the blower runs, and an unused opcode.
      directed_plan = '{
         plan(OP_STATUS,      DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0,    1'b1, 1'b0),
         plan(OP_LIGHT_QUERY, DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd1023, 1'b1, 1'b1),
         plan(OP_LIGHT_QUERY, DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0,    1'b1, 1'b0),
         plan(OP_LIGHT_QUERY, DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd512,  1'b1, 1'b0),
         plan(OP_LIGHT_QUERY, DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd513,  1'b1, 1'b1),
         plan(OP_STATUS,      DEV_SPARE,      8'd0,   10'd0,    10'd0,    1'b1, 1'b0),
         plan(OP_ON,          DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_ON,          DEV_LAST_ROOM,  8'd0,   10'd0,    10'd0),
         plan(OP_ON,          DEV_TV,         8'd0,   10'd0,    10'd0),
         plan(OP_ON,          DEV_AC,         8'd0,   10'd0,    10'd0),
         plan(OP_ON,          DEV_SPARE,      8'd0,   10'd0,    10'd0),
         plan(OP_STATUS,      DEV_TV,         8'd0,   10'd0,    10'd0),
         plan(OP_OFF,         DEV_LAST_ROOM,  8'd0,   10'd0,    10'd0),
         plan(OP_SET_TARGET,  DEV_FIRST_ROOM, 8'd255, 10'd0,    10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd1023, 10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_SET_TARGET,  DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd124,  10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd3,    10'd0),
         plan(OP_BLOWER_ON,   DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd1023, 10'd0),
         plan(OP_CLIMATE_OFF, DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_TICK,        DEV_FIRST_ROOM, 8'd0,   10'd1023, 10'd0),
         plan(OP_BLOWER_OFF,  DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_LAST_CODE,   DEV_SPARE,      8'd255, 10'd1023, 10'd1023),
         plan(OP_CLIMATE_ON,  DEV_FIRST_ROOM, 8'd0,   10'd0,    10'd0),
         plan(OP_STATUS,      DEV_AC,         8'd0,   10'd0,    10'd0)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: evaluate on every tick and use a short PWM period
      // so that the fan pin moves within a handful of ticks.
      setting               = defaults;
      setting.pwm_period    = 8'd8;
      setting.sensor_period = 8'd1;
      load_settings(setting);
      for (row = 0; row < directed_plan.size(); row++) begin
         if (row != 0) sender_gap();
         offer_request(directed_plan[row].item, directed_plan[row].pinned,
                       directed_plan[row].reply);
      end
      settle();

      // Every threshold at its lowest value and both periods at 1.
      setting = '{light_threshold: 10'd0, heater_below: 8'd0, ac_above: 8'd0,
                  fan_start: 8'd0, fan_full: 8'd0, pwm_period: 8'd1, sensor_period: 8'd1};
      run_phase(setting, 80, 1'b0);

      // Every register at its highest value.
      setting = '{light_threshold: 10'd1023, heater_below: 8'd255, ac_above: 8'd255,
                  fan_start: 8'd255, fan_full: 8'd255, pwm_period: 8'd255,
                  sensor_period: 8'd255};
      run_phase(setting, 80, 1'b0);

      // Zero periods: the PWM counter sticks at zero and every tick evaluates.
      setting               = defaults;
      setting.pwm_period    = 8'd0;
      setting.sensor_period = 8'd0;
      run_phase(setting, 60, 1'b0);

      // A wide ramp where the auto fan duty saturates; the long receiver
      // hold-off happens in this phase.
      setting = '{light_threshold: 10'd300, heater_below: 8'd60, ac_above: 8'd120,
                  fan_start: 8'd10, fan_full: 8'd200, pwm_period: 8'd255,
                  sensor_period: 8'd2};
      run_phase(setting, 100, 1'b1);

      for (round = 0; round < 3; round++) begin
         setting.light_threshold = 10'($urandom_range(0, 1023));
         setting.heater_below    = 8'($urandom_range(0, 255));
         setting.ac_above        = 8'($urandom_range(0, 255));
         setting.fan_start       = 8'($urandom_range(0, 255));
         setting.fan_full        = 8'($urandom_range(0, 255));
         setting.pwm_period      = 8'($urandom_range(1, 12));
         setting.sensor_period   = 8'($urandom_range(1, 12));
         run_phase(setting, 100, 1'b0);
      end

      // Closing stretch: back to the reset values with frequent evaluation,
      // and neither side idles.
      steady_traffic        = 1'b1;
      setting               = defaults;
      setting.sensor_period = 8'd3;
      run_phase(setting, 100, 1'b0);

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #LIMIT_TIME;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/cfpc_pkg.sv
design/cfpc_csr.sv
design/cfpc_engine.sv
design/climate_fan_pwm_controller_core.sv
bench/climate_fan_pwm_controller_core_tb.sv
